/* sv/wfhc_pkg.sv */
// ----------------------------------------------------------------------------
// wfhc_pkg
// Types and constants shared by the word frequency hash counter.
// ----------------------------------------------------------------------------
package wfhc_pkg;

  localparam int TABLE_SIZE   = 1024;
  localparam int MAX_WORD_LEN = 32;
  localparam int SLOT_W       = 10;
  localparam int LEN_W        = 6;
  localparam int KEY_W        = MAX_WORD_LEN * 8;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [1:0] {
    ST_NEW  = 2'd0,
    ST_INC  = 2'd1,
    ST_FULL = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             occ;
    logic [LEN_W-1:0] len;
    logic [31:0]      count;
    logic [KEY_W-1:0] key;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

/* sv/wfhc_ram.sv */
// ----------------------------------------------------------------------------
// wfhc_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wfhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/word_frequency_hash_counter.sv */
// ----------------------------------------------------------------------------
// word_frequency_hash_counter
// Counts case-sensitive words of a byte stream in a djb2 hash table.
// ----------------------------------------------------------------------------
// Input channel: one text byte per beat with an end_of_text mark. Letters and
// digits build a word; any other byte or the end mark closes it.
// Output channel: one beat per finished word with slot, count, hash, status.
// A word byte is taken while the block is idle. Each probe of a word end
// reads the table in S_READ, then compares and writes back in S_CMP; S_DONE
// hands the result to the output register.
// The table lives in one row-wide memory with a single read port, which sets
// the probe rate. Bytes keep being accepted while a result waits in the
// output register; a further word end is probed, but its result waits
// in S_DONE, with input stalled, until that register frees. After reset a
// clearing pass writes every one of the 1024 rows, with in_stall high.
// A stalled output holds its beat unchanged.
// ----------------------------------------------------------------------------
module word_frequency_hash_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  slot_index,
  output logic [31:0] word_count,
  output logic [31:0] word_hash,
  output logic [1:0]  status
);
  import wfhc_pkg::*;

  state_t state, state_next;

  logic [SLOT_W-1:0] clr_addr;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W:0]   probes;
  logic [7:0]        wbuf [MAX_WORD_LEN];
  logic [LEN_W-1:0]  word_length;
  logic [31:0]       running_hash;
  logic              word_too_long;

  logic [SLOT_W-1:0] res_slot;
  logic [31:0]       res_count;
  logic [31:0]       res_hash;
  status_t           res_status;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  row_t              ram_wdata, ram_q;
  logic [ROW_W-1:0]  ram_q_bits;

  logic              accept, is_word, word_open, finishes;
  logic [KEY_W-1:0]  buf_key;
  logic              key_eq, found, last_probe;
  logic [31:0]       cnt_inc;
  logic              out_free;

  wfhc_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_SIZE)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(pos),
    .rdata(ram_q_bits)
  );

  assign ram_q = row_t'(ram_q_bits);

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_word   = !end_of_text &&
                     ((text_byte >= 8'h30 && text_byte <= 8'h39) ||
                      (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
                      (text_byte >= 8'h61 && text_byte <= 8'h7A));
  assign word_open = (word_length != '0) || word_too_long;
  assign finishes  = accept && !is_word && word_open;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    logic [MAX_WORD_LEN-1:0] byte_eq;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      buf_key[i*8 +: 8] = wbuf[i];
      byte_eq[i] = (LEN_W'(i) >= word_length) || (ram_q.key[i*8 +: 8] == wbuf[i]);
    end
    key_eq     = (ram_q.len == word_length) && (&byte_eq);
    found      = ram_q.occ && key_eq;
    cnt_inc    = (ram_q.count == '1) ? ram_q.count : ram_q.count + 32'd1;
    last_probe = (probes == (SLOT_W+1)'(TABLE_SIZE - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == SLOT_W'(TABLE_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (finishes) begin
          state_next = word_too_long ? S_DONE : S_READ;
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (!ram_q.occ || found || last_probe) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_READ: ram_re = 1'b1;
      S_CMP: begin
        if (!ram_q.occ) begin
          ram_we          = 1'b1;
          ram_wdata.occ   = 1'b1;
          ram_wdata.len   = word_length;
          ram_wdata.count = 32'd1;
          ram_wdata.key   = buf_key;
        end else if (found) begin
          ram_we          = 1'b1;
          ram_wdata       = ram_q;
          ram_wdata.count = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      word_length   <= '0;
      running_hash  <= HASH_SEED;
      word_too_long <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_addr <= clr_addr + SLOT_W'(1);
        S_IDLE: begin
          if (accept && is_word) begin
            running_hash <= (running_hash << 5) + running_hash + 32'(text_byte);
            if (word_too_long || word_length >= LEN_W'(MAX_WORD_LEN)) begin
              word_too_long <= 1'b1;
            end else begin
              wbuf[word_length[$clog2(MAX_WORD_LEN)-1:0]] <= text_byte;
              word_length <= word_length + LEN_W'(1);
            end
          end else if (finishes) begin
            res_hash   <= running_hash;
            pos        <= running_hash[SLOT_W-1:0];
            probes     <= '0;
            res_slot   <= '0;
            res_count  <= '0;
            res_status <= ST_LONG;
          end
        end
        S_CMP: begin
          if (!ram_q.occ) begin
            res_slot   <= pos;
            res_count  <= 32'd1;
            res_status <= ST_NEW;
          end else if (found) begin
            res_slot   <= pos;
            res_count  <= cnt_inc;
            res_status <= ST_INC;
          end else if (last_probe) begin
            res_slot   <= '0;
            res_count  <= '0;
            res_status <= ST_FULL;
          end else begin
            pos    <= pos + SLOT_W'(1);
            probes <= probes + (SLOT_W+1)'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            slot_index    <= res_slot;
            word_count    <= res_count;
            word_hash     <= res_hash;
            status        <= res_status;
            word_length   <= '0;
            running_hash  <= HASH_SEED;
            word_too_long <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the word frequency hash counter against a behavioral word table.
// Byte beats are queued by an initial block and sent by a clocked driver;
// each finished word is predicted from a local table and compared per field
// with the output beats as the monitor takes them.
// ----------------------------------------------------------------------------
module tb_top;
  import wfhc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } beat_t;

  typedef struct packed {
    logic [9:0]  slot;
    logic [31:0] count;
    logic [31:0] hash;
    status_t     st;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  slot_index;
  logic [31:0] word_count;
  logic [31:0] word_hash;
  logic [1:0]  status;

  word_frequency_hash_counter u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_index(slot_index), .word_count(word_count),
    .word_hash(word_hash), .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predicted word table
  logic [7:0]  key_mem [TABLE_SIZE][MAX_WORD_LEN];
  int          key_len [TABLE_SIZE];
  bit          occupied [TABLE_SIZE];
  logic [31:0] counts [TABLE_SIZE];
  logic [7:0]  cur_word [MAX_WORD_LEN];
  int          cur_len = 0;
  logic [31:0] cur_hash = HASH_SEED;
  bit          cur_long = 0;

  beat_t  pending_beats[$];
  tally_t expected_tallies[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  bit     hold_send = 0;

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit same_key(int s);
    if (key_len[s] != cur_len) return 0;
    for (int i = 0; i < cur_len; i++)
      if (key_mem[s][i] != cur_word[i]) return 0;
    return 1;
  endfunction

  task automatic count_beat(beat_t b);
    tally_t t;
    int pos;
    bit open;
    open = cur_len != 0 || cur_long;
    if (!b.eot && is_word_char(b.ch)) begin
      cur_hash = cur_hash * 33 + b.ch;
      if (cur_long || cur_len >= MAX_WORD_LEN) cur_long = 1;
      else begin
        cur_word[cur_len] = b.ch;
        cur_len++;
      end
      return;
    end
    if (!open) return;
    t = '0;
    t.hash = cur_hash;
    if (cur_long) t.st = ST_LONG;
    else begin
      t.st = ST_FULL;
      pos = cur_hash % TABLE_SIZE;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (!occupied[pos]) begin
          for (int i = 0; i < cur_len; i++) key_mem[pos][i] = cur_word[i];
          key_len[pos] = cur_len;
          counts[pos] = 1;
          occupied[pos] = 1;
          t.slot = 10'(pos);
          t.count = 1;
          t.st = ST_NEW;
          break;
        end
        if (same_key(pos)) begin
          if (counts[pos] != 32'hFFFF_FFFF) counts[pos]++;
          t.slot = 10'(pos);
          t.count = counts[pos];
          t.st = ST_INC;
          break;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
    end
    expected_tallies.push_back(t);
    cur_len = 0;
    cur_hash = HASH_SEED;
    cur_long = 0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range("0", "9"));
      1: return 8'($urandom_range("A", "Z"));
      default: return 8'($urandom_range("a", "z"));
    endcase
  endfunction

  function automatic logic [7:0] delim_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_word_char(c));
    return c;
  endfunction

  task automatic push_word(string w, logic [7:0] d);
    for (int i = 0; i < w.len(); i++) pending_beats.push_back('{w[i], 1'b0});
    pending_beats.push_back('{d, 1'b0});
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        count_beat(pending_beats.pop_front());
        send_gap <= pick_gap();
      end
      if (in_valid && in_stall) begin
      end else if (pending_beats.size() != 0 && !hold_send && send_gap == 0 &&
                   !(in_valid && !in_stall && send_gap != 0)) begin
        in_valid <= 1'b1;
        text_byte <= pending_beats[0].ch;
        end_of_text <= pending_beats[0].eot;
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0 && !(in_valid && !in_stall)) send_gap <= send_gap - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: slot %0d count %0d hash %h status %0d",
                                         slot_index, word_count, word_hash, status);
        end else begin
          tally_t t;
          t = expected_tallies.pop_front();
          if (slot_index !== t.slot || word_count !== t.count || word_hash !== t.hash ||
              status !== t.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp slot %0d count %0d hash %h status %0d, got %0d %0d %h %0d",
                       t.slot, t.count, t.hash, t.st, slot_index, word_count, word_hash,
                       status);
          end
        end
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    string longw;
    int nwords;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of byte values and the new, repeat and overlong cases
    pending_beats.push_back('{8'h20, 1'b0});
    pending_beats.push_back('{8'h00, 1'b1});
    push_word("0", 8'h00);
    push_word("9", 8'hFF);
    push_word("Az", 8'h2F);
    push_word("az", 8'h3A);
    push_word("AZ", 8'h40);
    push_word("Az", 8'h5B);
    push_word("Z", 8'h60);
    push_word("a", 8'h7B);
    push_word("0", 8'h80);
    longw = "";
    for (int i = 0; i < MAX_WORD_LEN; i++) longw = {longw, "x"};
    push_word(longw, 8'h2C);
    push_word({longw, "y"}, 8'h2C);
    push_word(longw, 8'h2C);
    pending_beats.push_back('{8'hFF, 1'b1});
    pending_beats.push_back('{"q", 1'b0});
    pending_beats.push_back('{8'h55, 1'b1});

    // sender pauses until everything drained
    wait (pending_beats.size() == 0);
    hold_send = 1;
    push_word("drain", 8'h0A);
    wait (expected_tallies.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    hold_send = 0;

    // random: mostly words from a small vocabulary so counts grow
    nwords = 0;
    while (nwords < 220) begin
      int len;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) len = $urandom_range(MAX_WORD_LEN - 1, MAX_WORD_LEN + 4);
      else if (r < 12) len = $urandom_range(1, 2);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        pending_beats.push_back('{(r < 12) ? 8'("a" + $urandom_range(0, 3)) : word_char(),
                                  1'b0});
      if ($urandom_range(0, 9) == 0)
        pending_beats.push_back('{8'($urandom_range(0, 255)), 1'b1});
      else pending_beats.push_back('{delim_char(), 1'b0});
      if ($urandom_range(0, 7) == 0) pending_beats.push_back('{delim_char(), 1'b0});
      nwords++;
    end
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_tallies.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
sv/wfhc_pkg.sv
sv/wfhc_ram.sv
sv/word_frequency_hash_counter.sv
bench/tb_top.sv
